### rtl/slip_multiplex_rx_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef SLIP_MULTIPLEX_RX_DEFRAMER_MACROS_SVH
`define SLIP_MULTIPLEX_RX_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define SMRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### rtl/smrd_pkg.sv
package smrd_pkg;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [7:0] STDIO_START_RST  = 8'd10;
  localparam logic [7:0] CONFIG_START_RST = 8'd169;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_NET     = 3'd1,
    ST_NET_ESC = 3'd2,
    ST_STD     = 3'd3,
    ST_STD_ESC = 3'd4,
    ST_CFG     = 3'd5,
    ST_CFG_ESC = 3'd6
  } state_t;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_NET  = 2'd1,
    CH_STD  = 2'd2,
    CH_CFG  = 2'd3
  } chan_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DONE = 2'd1,
    EV_DROP = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    REG_STDIO_ENABLE      = 2'd0,
    REG_CONFIG_ENABLE     = 2'd1,
    REG_STDIO_START_BYTE  = 2'd2,
    REG_CONFIG_START_BYTE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       net_start_ok;
    logic       net_add_ok;
    logic       cfg_start_ok;
    logic       cfg_add_ok;
  } in_beat_t;

  typedef struct packed {
    chan_t      channel;
    logic       data_valid;
    logic [7:0] data_byte;
    event_t     frame_event;
  } out_beat_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == SLIP_ESC_END) begin
      r = SLIP_END;
    end else if (b == SLIP_ESC_ESC) begin
      r = SLIP_ESC;
    end
    return r;
  endfunction

endpackage

### rtl/slip_multiplex_rx_deframer.sv
// SLIP receive deframer with slipmux channel demultiplexing. One raw serial byte is
// accepted per cycle while in_stall is low, and every accepted beat produces exactly
// one result beat: an unescaped payload byte tagged with its channel, a frame-complete
// or frame-dropped mark, or an empty result. A beat is registered in the input
// register, decoded combinationally against the seven-state receive register, and
// then registered in the result register, which holds it while out_stall is high.
// Sustained, the rate is one byte per cycle while the output does not stall. The
// buffer room flags travel with each byte. Configuration writes are
// taken at any time but should only be issued while no byte is in flight.
`include "slip_multiplex_rx_deframer_macros.svh"

module slip_multiplex_rx_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smrd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output smrd_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  smrd_pkg::reg_idx_t  cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic               stdio_enable_r;
  logic               config_enable_r;
  logic [7:0]         stdio_start_byte_r;
  logic [7:0]         config_start_byte_r;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  smrd_pkg::in_beat_t s1_data_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  smrd_pkg::out_beat_t out_data_r;
  smrd_pkg::out_beat_t out_data_nxt;

  smrd_pkg::state_t state_r;
  smrd_pkg::state_t state_nxt;

  logic       out_free;
  logic       advance;
  logic       in_take;
  logic [7:0] b;
  logic [7:0] b_unesc;
  logic       std_hit;
  logic       cfg_hit;
  logic       out_dv;
  logic       drop_taken;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stdio_enable_r      <= 1'b0;
      config_enable_r     <= 1'b0;
      stdio_start_byte_r  <= smrd_pkg::STDIO_START_RST;
      config_start_byte_r <= smrd_pkg::CONFIG_START_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        smrd_pkg::REG_STDIO_ENABLE:      stdio_enable_r      <= cfg_wdata[0];
        smrd_pkg::REG_CONFIG_ENABLE:     config_enable_r     <= cfg_wdata[0];
        smrd_pkg::REG_STDIO_START_BYTE:  stdio_start_byte_r  <= cfg_wdata;
        smrd_pkg::REG_CONFIG_START_BYTE: config_start_byte_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register is free.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= smrd_pkg::ST_IDLE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign b       = s1_data_r.rx_byte;
  assign b_unesc = smrd_pkg::unescape(b);
  assign std_hit = stdio_enable_r && (b == stdio_start_byte_r);
  assign cfg_hit = (b == config_start_byte_r);

  // Next receive state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smrd_pkg::ST_STD: begin
        if (b == smrd_pkg::SLIP_ESC) begin
          state_nxt = smrd_pkg::ST_STD_ESC;
        end else if (b == smrd_pkg::SLIP_END) begin
          state_nxt = smrd_pkg::ST_IDLE;
        end else begin
          state_nxt = smrd_pkg::ST_STD;
        end
      end
      smrd_pkg::ST_STD_ESC: begin
        state_nxt = smrd_pkg::ST_STD;
      end
      smrd_pkg::ST_CFG, smrd_pkg::ST_CFG_ESC: begin
        if (state_r == smrd_pkg::ST_CFG && b == smrd_pkg::SLIP_ESC) begin
          state_nxt = smrd_pkg::ST_CFG_ESC;
        end else if (state_r == smrd_pkg::ST_CFG && b == smrd_pkg::SLIP_END) begin
          state_nxt = smrd_pkg::ST_IDLE;
        end else if (config_enable_r && !s1_data_r.cfg_add_ok) begin
          state_nxt = smrd_pkg::ST_IDLE;
        end else begin
          state_nxt = smrd_pkg::ST_CFG;
        end
      end
      smrd_pkg::ST_NET, smrd_pkg::ST_NET_ESC: begin
        if (state_r == smrd_pkg::ST_NET && b == smrd_pkg::SLIP_ESC) begin
          state_nxt = smrd_pkg::ST_NET_ESC;
        end else if (state_r == smrd_pkg::ST_NET && b == smrd_pkg::SLIP_END) begin
          state_nxt = smrd_pkg::ST_IDLE;
        end else if (s1_data_r.net_add_ok) begin
          state_nxt = smrd_pkg::ST_NET;
        end else begin
          state_nxt = smrd_pkg::ST_IDLE;
        end
      end
      default: begin
        if (std_hit) begin
          state_nxt = smrd_pkg::ST_STD;
        end else if (cfg_hit) begin
          if (config_enable_r && !s1_data_r.cfg_start_ok) begin
            state_nxt = smrd_pkg::ST_IDLE;
          end else begin
            state_nxt = smrd_pkg::ST_CFG;
          end
        end else if (b == smrd_pkg::SLIP_END || !s1_data_r.net_start_ok) begin
          state_nxt = smrd_pkg::ST_IDLE;
        end else if (b == smrd_pkg::SLIP_ESC) begin
          state_nxt = smrd_pkg::ST_NET_ESC;
        end else if (s1_data_r.net_add_ok) begin
          state_nxt = smrd_pkg::ST_NET;
        end else begin
          state_nxt = smrd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Result beat.
  always_comb begin
    out_data_nxt = '{channel: smrd_pkg::CH_NONE, data_valid: 1'b0, data_byte: 8'd0,
                     frame_event: smrd_pkg::EV_NONE};
    case (state_r)
      smrd_pkg::ST_STD, smrd_pkg::ST_STD_ESC: begin
        if (state_r == smrd_pkg::ST_STD_ESC ||
            (b != smrd_pkg::SLIP_ESC && b != smrd_pkg::SLIP_END)) begin
          if (stdio_enable_r) begin
            out_data_nxt.channel    = smrd_pkg::CH_STD;
            out_data_nxt.data_valid = 1'b1;
            out_data_nxt.data_byte  = (state_r == smrd_pkg::ST_STD_ESC) ? b_unesc : b;
          end
        end
      end
      smrd_pkg::ST_CFG, smrd_pkg::ST_CFG_ESC: begin
        if (state_r == smrd_pkg::ST_CFG && b == smrd_pkg::SLIP_ESC) begin
          out_data_nxt.channel = smrd_pkg::CH_NONE;
        end else if (state_r == smrd_pkg::ST_CFG && b == smrd_pkg::SLIP_END) begin
          if (config_enable_r) begin
            out_data_nxt.channel     = smrd_pkg::CH_CFG;
            out_data_nxt.frame_event = smrd_pkg::EV_DONE;
          end
        end else if (config_enable_r) begin
          out_data_nxt.channel = smrd_pkg::CH_CFG;
          if (s1_data_r.cfg_add_ok) begin
            out_data_nxt.data_valid = 1'b1;
            out_data_nxt.data_byte  = (state_r == smrd_pkg::ST_CFG_ESC) ? b_unesc : b;
          end else begin
            out_data_nxt.frame_event = smrd_pkg::EV_DROP;
          end
        end
      end
      smrd_pkg::ST_NET, smrd_pkg::ST_NET_ESC: begin
        if (state_r == smrd_pkg::ST_NET && b == smrd_pkg::SLIP_ESC) begin
          out_data_nxt.channel = smrd_pkg::CH_NONE;
        end else if (state_r == smrd_pkg::ST_NET && b == smrd_pkg::SLIP_END) begin
          out_data_nxt.channel     = smrd_pkg::CH_NET;
          out_data_nxt.frame_event = smrd_pkg::EV_DONE;
        end else begin
          out_data_nxt.channel = smrd_pkg::CH_NET;
          if (s1_data_r.net_add_ok) begin
            out_data_nxt.data_valid = 1'b1;
            out_data_nxt.data_byte  = (state_r == smrd_pkg::ST_NET_ESC) ? b_unesc : b;
          end else begin
            out_data_nxt.frame_event = smrd_pkg::EV_DROP;
          end
        end
      end
      default: begin
        if (std_hit) begin
          out_data_nxt.channel = smrd_pkg::CH_NONE;
        end else if (cfg_hit) begin
          if (config_enable_r && !s1_data_r.cfg_start_ok) begin
            out_data_nxt.channel     = smrd_pkg::CH_CFG;
            out_data_nxt.frame_event = smrd_pkg::EV_DROP;
          end
        end else if (b == smrd_pkg::SLIP_END) begin
          out_data_nxt.channel = smrd_pkg::CH_NONE;
        end else if (!s1_data_r.net_start_ok) begin
          out_data_nxt.channel     = smrd_pkg::CH_NET;
          out_data_nxt.frame_event = smrd_pkg::EV_DROP;
        end else if (b != smrd_pkg::SLIP_ESC) begin
          out_data_nxt.channel = smrd_pkg::CH_NET;
          if (s1_data_r.net_add_ok) begin
            out_data_nxt.data_valid = 1'b1;
            out_data_nxt.data_byte  = b;
          end else begin
            out_data_nxt.frame_event = smrd_pkg::EV_DROP;
          end
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_dv     = out_valid && out_data.data_valid;
  assign drop_taken = advance && (out_data_nxt.frame_event == smrd_pkg::EV_DROP);

  `SMRD_ASSERT_NOW(a_data_no_event, clk, rst_n, out_dv, out_data.frame_event == smrd_pkg::EV_NONE)
  `SMRD_ASSERT_NOW(a_data_has_chan, clk, rst_n, out_dv, out_data.channel != smrd_pkg::CH_NONE)
  `SMRD_ASSERT_NEXT(a_drop_to_idle, clk, rst_n, drop_taken, state_r == smrd_pkg::ST_IDLE)
  `SMRD_ASSERT_NOW(a_stall_when_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r)

endmodule
